### hdl/pfd_pkg.sv
`default_nettype none

package pfd_pkg;

  localparam int GRID   = 5;
  localparam int CELLS  = GRID * GRID;
  localparam int CODE_W = 5;
  localparam int POS_W  = 3;
  localparam int IDX_W  = 5;
  localparam int CHAR_W = 8;
  localparam int WIDE_W = 60;
  localparam int WIDE_CELLS = WIDE_W / CODE_W;

  // config register indexes
  localparam logic [1:0] REG_CELLS_LOW = 2'd0;
  localparam logic [1:0] REG_CELLS_MID = 2'd1;
  localparam logic [1:0] REG_CELL_LAST = 2'd2;

  // reset square: M F H I K / U N O P Q / Z V W X Y / E L A R G / D S T B C
  localparam logic [WIDE_W-1:0] CELLS_LOW_RST = 60'd785332173373971628;
  localparam logic [WIDE_W-1:0] CELLS_MID_RST = 60'd58057736905188086;
  localparam logic [CODE_W-1:0] CELL_LAST_RST = 5'd2;

  localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_I = 8'h49;
  localparam logic [CHAR_W-1:0] CHAR_J = 8'h4A;
  localparam logic [CHAR_W-1:0] CHAR_Z = 8'h5A;

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(GRID - 1);

  typedef logic [CELLS-1:0][CODE_W-1:0] square_t;

  // step one position back around the square edge
  function automatic logic [POS_W-1:0] pos_back(input logic [POS_W-1:0] p);
    logic [POS_W-1:0] q;
    if (p == '0) begin
      q = POS_LAST;
    end else begin
      q = p - POS_W'(1);
    end
    return q;
  endfunction

endpackage

`default_nettype wire

### hdl/pfd_in_if.sv
`default_nettype none

interface pfd_in_if;
  import pfd_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] first_cipher_char;
  logic [CHAR_W-1:0] second_cipher_char;

  modport source (output valid, first_cipher_char, second_cipher_char, input ready);
  modport sink   (input valid, first_cipher_char, second_cipher_char, output ready);
endinterface

`default_nettype wire

### hdl/pfd_out_if.sv
`default_nettype none

interface pfd_out_if;
  import pfd_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] first_plain_char;
  logic [CHAR_W-1:0] second_plain_char;
  logic              not_found;

  modport source (output valid, first_plain_char, second_plain_char, not_found,
                  input ready);
  modport sink   (input valid, first_plain_char, second_plain_char, not_found,
                  output ready);
endinterface

`default_nettype wire

### hdl/playfair_pair_decrypt_core.sv
`default_nettype none

// Playfair pair decryption over a 5x5 key square. Each word on cipher_pair is
// one ciphertext pair of ASCII bytes; each word on plain_pair is the matching
// plaintext pair in uppercase ASCII, in order, one result per pair. 'J' is
// read as 'I'; only uppercase 'A'..'Z' can be found. If either byte is not in
// the square, not_found is set and both bytes come out unchanged. The square
// is held in three write-only registers (index 0: cells 0-11, index 1: cells
// 12-23, index 2: cell 24; five bits per cell, A=0, row-major) and resets to
// the square M F H I K / U N O P Q / Z V W X Y / E L A R G / D S T B C. When a
// letter appears twice, the first cell in row-major order wins. Write the
// square only while no pair is in flight. Throughput is one pair per clock
// while plain_pair is not stalled; the result word is formed by the four
// register stages (the first loads on the accepting edge): character
// normalize, 25-cell lookup, Playfair rule select, and cell read-out into
// the output register. A stall on plain_pair backs up stage by stage, so
// empty stages still fill while the output waits;
// cipher_pair.ready is high whenever plain_pair.ready is high.
module playfair_pair_decrypt_core (
  input  wire                          clk,
  input  wire                          rst,
  pfd_in_if.sink                       cipher_pair,
  pfd_out_if.source                    plain_pair,
  input  wire                          write_enable,
  input  wire [1:0]                    write_index,
  input  wire [pfd_pkg::WIDE_W-1:0]    write_data
);
  import pfd_pkg::*;

  // ---------------------------------------------------------------- config
  logic [WIDE_W-1:0] cells_low;
  logic [WIDE_W-1:0] cells_mid;
  logic [CODE_W-1:0] cell_last;
  square_t           square;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_low <= CELLS_LOW_RST;
      cells_mid <= CELLS_MID_RST;
      cell_last <= CELL_LAST_RST;
    end else if (write_enable) begin
      unique case (write_index)
        REG_CELLS_LOW: cells_low <= write_data;
        REG_CELLS_MID: cells_mid <= write_data;
        REG_CELL_LAST: cell_last <= write_data[CODE_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // flat view of the square, cell k at square[k]
  always_comb begin
    for (int k = 0; k < WIDE_CELLS; k++) begin
      square[k]              = cells_low[k*CODE_W +: CODE_W];
      square[k + WIDE_CELLS] = cells_mid[k*CODE_W +: CODE_W];
    end
    square[CELLS-1] = cell_last;
  end

  // ---------------------------------------------------------------- flow
  // Each stage loads when it is empty or the stage after it moves on.
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !s4_valid || plain_pair.ready;
  assign rdy3 = !s3_valid || rdy4;
  assign rdy2 = !s2_valid || rdy3;
  assign rdy1 = !s1_valid || rdy2;
  assign cipher_pair.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      if (rdy1) s1_valid <= cipher_pair.valid;
      if (rdy2) s2_valid <= s1_valid;
      if (rdy3) s3_valid <= s2_valid;
      if (rdy4) s4_valid <= s3_valid;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // J folds to I, then the letter code and whether the byte is a capital.
  logic [CHAR_W-1:0] s1_char_a, s1_char_b;
  logic [CODE_W-1:0] s1_code_a, s1_code_b;
  logic              s1_cap_a, s1_cap_b;
  logic [CHAR_W-1:0] norm_a, norm_b, diff_a, diff_b;

  always_comb begin
    norm_a = (cipher_pair.first_cipher_char == CHAR_J) ? CHAR_I
                                                        : cipher_pair.first_cipher_char;
    norm_b = (cipher_pair.second_cipher_char == CHAR_J) ? CHAR_I
                                                         : cipher_pair.second_cipher_char;
    diff_a = norm_a - CHAR_A;
    diff_b = norm_b - CHAR_A;
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_char_a <= cipher_pair.first_cipher_char;
      s1_char_b <= cipher_pair.second_cipher_char;
      s1_code_a <= diff_a[CODE_W-1:0];
      s1_code_b <= diff_b[CODE_W-1:0];
      s1_cap_a  <= (norm_a >= CHAR_A) && (norm_a <= CHAR_Z);
      s1_cap_b  <= (norm_b >= CHAR_A) && (norm_b <= CHAR_Z);
    end
  end

  // ---------------------------------------------------------------- stage 2
  // Compare against all 25 cells; scanning down makes the lowest hit win.
  logic [CHAR_W-1:0] s2_char_a, s2_char_b;
  logic [POS_W-1:0]  s2_row_a, s2_col_a, s2_row_b, s2_col_b;
  logic              s2_found;
  logic [POS_W-1:0]  hit_row_a, hit_col_a, hit_row_b, hit_col_b;
  logic              hit_a, hit_b;

  always_comb begin
    hit_row_a = '0;
    hit_col_a = '0;
    hit_row_b = '0;
    hit_col_b = '0;
    hit_a     = 1'b0;
    hit_b     = 1'b0;
    for (int k = CELLS - 1; k >= 0; k--) begin
      if (square[k] == s1_code_a) begin
        hit_a     = 1'b1;
        hit_row_a = POS_W'(k / GRID);
        hit_col_a = POS_W'(k % GRID);
      end
      if (square[k] == s1_code_b) begin
        hit_b     = 1'b1;
        hit_row_b = POS_W'(k / GRID);
        hit_col_b = POS_W'(k % GRID);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_char_a <= s1_char_a;
      s2_char_b <= s1_char_b;
      s2_row_a  <= hit_row_a;
      s2_col_a  <= hit_col_a;
      s2_row_b  <= hit_row_b;
      s2_col_b  <= hit_col_b;
      s2_found  <= s1_cap_a && s1_cap_b && hit_a && hit_b;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Playfair rule: same row -> step left, same column -> step up,
  // otherwise swap columns.
  logic [CHAR_W-1:0] s3_char_a, s3_char_b;
  logic [POS_W-1:0]  s3_row_a, s3_col_a, s3_row_b, s3_col_b;
  logic              s3_found;
  logic [POS_W-1:0]  rule_row_a, rule_col_a, rule_row_b, rule_col_b;

  always_comb begin
    if (s2_row_a == s2_row_b) begin
      rule_row_a = s2_row_a;
      rule_col_a = pos_back(s2_col_a);
      rule_row_b = s2_row_b;
      rule_col_b = pos_back(s2_col_b);
    end else if (s2_col_a == s2_col_b) begin
      rule_row_a = pos_back(s2_row_a);
      rule_col_a = s2_col_a;
      rule_row_b = pos_back(s2_row_b);
      rule_col_b = s2_col_b;
    end else begin
      rule_row_a = s2_row_a;
      rule_col_a = s2_col_b;
      rule_row_b = s2_row_b;
      rule_col_b = s2_col_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_char_a <= s2_char_a;
      s3_char_b <= s2_char_b;
      s3_row_a  <= rule_row_a;
      s3_col_a  <= rule_col_a;
      s3_row_b  <= rule_row_b;
      s3_col_b  <= rule_col_b;
      s3_found  <= s2_found;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // Read the chosen cells and form the output word.
  logic [IDX_W-1:0]  idx_a, idx_b;
  logic [CHAR_W-1:0] plain_a, plain_b;
  logic [CHAR_W-1:0] s4_char_a, s4_char_b;
  logic              s4_not_found;

  always_comb begin
    idx_a   = IDX_W'(s3_row_a) * IDX_W'(GRID) + IDX_W'(s3_col_a);
    idx_b   = IDX_W'(s3_row_b) * IDX_W'(GRID) + IDX_W'(s3_col_b);
    plain_a = CHAR_A + CHAR_W'(square[idx_a]);
    plain_b = CHAR_A + CHAR_W'(square[idx_b]);
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_char_a    <= s3_found ? plain_a : s3_char_a;
      s4_char_b    <= s3_found ? plain_b : s3_char_b;
      s4_not_found <= !s3_found;
    end
  end

  assign plain_pair.valid             = s4_valid;
  assign plain_pair.first_plain_char  = s4_char_a;
  assign plain_pair.second_plain_char = s4_char_b;
  assign plain_pair.not_found         = s4_not_found;

endmodule

`default_nettype wire

### hdl/pfd_checker.sv
`default_nettype none

module pfd_checker (
  input  wire       clk,
  input  wire       rst,
  input  wire       in_ready,
  input  wire       out_valid,
  input  wire       out_ready,
  input  wire [7:0] out_first,
  input  wire [7:0] out_second,
  input  wire       out_not_found
);
  import pfd_pkg::*;

  // pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word present right after reset");

  // a free output never blocks the input side
  a_ready_path: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output is free");

  // decoded letters always land in 'A' plus a five-bit code
  a_letter_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_not_found) |->
      (out_first >= CHAR_A) && (out_first <= CHAR_A + 8'd31) &&
      (out_second >= CHAR_A) && (out_second <= CHAR_A + 8'd31))
    else $error("decoded byte outside the letter code range");

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      out_valid && $stable(out_first) && $stable(out_second) && $stable(out_not_found))
    else $error("result word changed while stalled");

endmodule

bind playfair_pair_decrypt_core pfd_checker u_pfd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (cipher_pair.ready),
  .out_valid     (plain_pair.valid),
  .out_ready     (plain_pair.ready),
  .out_first     (plain_pair.first_plain_char),
  .out_second    (plain_pair.second_plain_char),
  .out_not_found (plain_pair.not_found)
);

`default_nettype wire
